/* rtl/pac_pkg.sv */
package pac_pkg;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_C  = 8'h63;
  localparam logic [7:0] CH_LO_D  = 8'h64;
  localparam logic [7:0] CH_LO_E  = 8'h65;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;

  localparam logic [2:0] COUNT_MAX = 3'd5;
  localparam logic [2:0] HEX_MAX   = 3'd4;
  localparam logic [1:0] LABEL_MAX = 2'd2;
  localparam logic [8:0] OCTET_OVF = 9'd256;

  typedef enum logic [2:0] {
    KIND_EMPTY  = 3'd0,
    KIND_IPV6   = 3'd1,
    KIND_LABEL  = 3'd2,
    KIND_QUAD   = 3'd3,
    KIND_DOMAIN = 3'd4
  } kind_t;

  typedef struct packed {
    logic [2:0][7:0] octet_store;
    logic [8:0]      current_value;
    logic [2:0]      octet_count;
    logic            in_octet_flag;
    logic            malformed_flag;
    logic            overflow_flag;
    logic            seen_colon;
    logic            seen_dot;
    logic            seen_other_char;
    logic [3:0][7:0] prefix_chars;
    logic [2:0]      char_count;
    logic [2:0]      hex_label_count;
    logic [1:0]      label_length;
    logic            label_is_hex;
  } scan_t;

endpackage

/* rtl/pac_in_if.sv */
interface pac_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;
  logic       empty_string;

  modport source (output valid, character, last, empty_string, input ready);
  modport sink (input valid, character, last, empty_string, output ready);
endinterface

/* rtl/pac_out_if.sv */
interface pac_out_if;
  logic       valid;
  logic       ready;
  logic       is_public;
  logic [2:0] address_kind;

  modport source (output valid, is_public, address_kind, input ready);
  modport sink (input valid, is_public, address_kind, output ready);
endinterface

/* rtl/pac_scan.sv */
module pac_scan
  import pac_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic       finish,
  input  logic       empty_string,
  input  logic [7:0] character,
  output scan_t      scan
);

  scan_t state;
  scan_t taken;
  logic  is_digit;
  logic  is_hex;
  logic [11:0] value_x10;
  logic [11:0] value_sum;

  always_comb begin
    is_digit  = (character >= CH_ZERO) && (character <= CH_NINE);
    is_hex    = is_digit || ((character >= CH_LO_A) && (character <= CH_LO_F)) ||
                ((character >= CH_UP_A) && (character <= CH_UP_F));
    value_x10 = {state.current_value, 3'b000} + {2'b00, state.current_value, 1'b0};
    value_sum = value_x10 + {8'd0, character[3:0] - CH_ZERO[3:0]};

    taken = state;
    if (state.char_count < 3'd4) begin
      taken.prefix_chars[state.char_count[1:0]] = character;
    end
    if (state.char_count < COUNT_MAX) begin
      taken.char_count = state.char_count + 3'd1;
    end

    if (is_digit) begin
      if (state.octet_count >= 3'd4) begin
        taken.malformed_flag = 1'b1;
      end else if (!state.overflow_flag) begin
        if (value_sum > 12'd255) begin
          taken.overflow_flag = 1'b1;
          taken.current_value = OCTET_OVF;
        end else begin
          taken.current_value = value_sum[8:0];
        end
      end
      taken.in_octet_flag = 1'b1;
    end else if (character == CH_DOT) begin
      taken.seen_dot = 1'b1;
      if (!state.in_octet_flag || state.overflow_flag) begin
        taken.malformed_flag = 1'b1;
      end
      if (state.octet_count < 3'd3) begin
        taken.octet_store[state.octet_count[1:0]] = state.current_value[7:0];
      end
      if (state.octet_count < COUNT_MAX) begin
        taken.octet_count = state.octet_count + 3'd1;
      end
      taken.current_value = '0;
      taken.overflow_flag = 1'b0;
      taken.in_octet_flag = 1'b0;
    end else if (character == CH_COLON) begin
      taken.seen_colon = 1'b1;
    end else begin
      taken.seen_other_char = 1'b1;
    end

    if (character == CH_DOT) begin
      // a dot closes the label: count it if it was a lone hex digit
      if (state.label_length == 2'd1 && state.label_is_hex &&
          state.hex_label_count < HEX_MAX) begin
        taken.hex_label_count = state.hex_label_count + 3'd1;
      end
      taken.label_length = '0;
      taken.label_is_hex = 1'b0;
    end else begin
      if (state.label_length == 2'd0) begin
        taken.label_is_hex = is_hex;
      end
      if (state.label_length < LABEL_MAX) begin
        taken.label_length = state.label_length + 2'd1;
      end
    end

    scan = empty_string ? state : taken;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (step) begin
      if (finish) begin
        state <= '0;
      end else begin
        state <= scan;
      end
    end
  end

endmodule

/* rtl/pac_judge.sv */
module pac_judge
  import pac_pkg::*;
(
  input  scan_t scan,
  output logic  is_public,
  output kind_t kind
);

  logic       v6_pub;
  logic       quad_pub;
  logic       domain_pub;
  logic [2:0] hex_closed;
  logic [7:0] a;
  logic [7:0] b;
  logic [7:0] p0;
  logic [7:0] p1;
  logic [7:0] p2;
  logic [7:0] p3;

  always_comb begin
    a  = scan.octet_store[0];
    b  = scan.octet_store[1];
    p0 = scan.prefix_chars[0];
    p1 = scan.prefix_chars[1];
    p2 = scan.prefix_chars[2];
    p3 = scan.prefix_chars[3];

    // the open label is closed at string end
    hex_closed = scan.hex_label_count;
    if (scan.label_length == 2'd1 && scan.label_is_hex && scan.hex_label_count < HEX_MAX) begin
      hex_closed = scan.hex_label_count + 3'd1;
    end

    v6_pub = 1'b1;
    if (scan.char_count == 3'd3 && p0 == CH_COLON && p1 == CH_COLON && p2 == CH_ONE) begin
      v6_pub = 1'b0;
    end
    if (scan.char_count == 3'd2 && p0 == CH_COLON && p1 == CH_COLON) begin
      v6_pub = 1'b0;
    end
    if (scan.char_count >= 3'd2 && p0 == CH_LO_F &&
        (p1 == CH_LO_F || p1 == CH_LO_C || p1 == CH_LO_D)) begin
      v6_pub = 1'b0;
    end
    if (scan.char_count >= 3'd4 && p0 == CH_LO_F && p1 == CH_LO_E &&
        p2 == CH_EIGHT && p3 == CH_ZERO) begin
      v6_pub = 1'b0;
    end

    quad_pub = scan.in_octet_flag && !scan.overflow_flag &&
               scan.octet_count == 3'd3 && !scan.malformed_flag;
    if (a == 8'd0 || a == 8'd10 || a == 8'd127) quad_pub = 1'b0;
    if (a == 8'd169 && b == 8'd254) quad_pub = 1'b0;
    if (a == 8'd172 && b >= 8'd16 && b <= 8'd31) quad_pub = 1'b0;
    if (a == 8'd192 && b == 8'd168) quad_pub = 1'b0;
    if (a == 8'd100 && b >= 8'd64 && b <= 8'd127) quad_pub = 1'b0;
    if (a >= 8'd224) quad_pub = 1'b0;

    domain_pub = (hex_closed < HEX_MAX) &&
                 !(scan.char_count >= 3'd2 && p0 == CH_ZERO && p1 == CH_DOT);

    if (scan.char_count == 3'd0) begin
      kind      = KIND_EMPTY;
      is_public = 1'b0;
    end else if (scan.seen_colon) begin
      kind      = KIND_IPV6;
      is_public = v6_pub;
    end else if (!scan.seen_dot) begin
      kind      = KIND_LABEL;
      is_public = p0 != CH_ZERO;
    end else if (!scan.seen_other_char) begin
      kind      = KIND_QUAD;
      is_public = quad_pub;
    end else begin
      kind      = KIND_DOMAIN;
      is_public = domain_pub;
    end
  end

endmodule

/* rtl/public_address_classifier.sv */
// Public address classifier.
// text:    one beat per character of an address string; last marks the final
//          character, empty_string ends the string with no character added.
// verdict: one beat per string end, carrying is_public and address_kind
//          (empty, IPv6 literal, single label, dotted quad, domain name).
// Pipeline: two register stages, the input register and the verdict register;
//          a string end is judged on leaving the first and held in the second.
// Throughput: one character per cycle, back to back, but for the stall below;
//          a beat is folded into the scan state by one short compare-add pass.
// Stall: while the verdict register holds an untaken beat, further
//          characters that do not end a string still flow into the scan
//          state; a second string end waits in the input register and
//          text.ready drops until the verdict beat is taken.
// Reset: rst (synchronous) empties both stages and clears the scan state, so
//          the next beat starts a new string.
module public_address_classifier
  import pac_pkg::*;
(
  input logic   clk,
  input logic   rst,
  pac_in_if.sink    text,
  pac_out_if.source verdict
);

  logic       held;
  logic [7:0] held_char;
  logic       held_last;
  logic       held_empty;
  logic       held_end;
  logic       advance;
  logic       out_valid;
  logic       out_public;
  kind_t      out_kind;
  scan_t      scan;
  logic       judge_public;
  kind_t      judge_kind;

  assign held_end   = held_empty || held_last;
  assign advance    = held && (!held_end || !out_valid || verdict.ready);
  assign text.ready = !held || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (text.valid && text.ready) begin
      held <= 1'b1;
    end else if (advance) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      held_char  <= text.character;
      held_last  <= text.last;
      held_empty <= text.empty_string;
    end
  end

  pac_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .finish       (held_end),
    .empty_string (held_empty),
    .character    (held_char),
    .scan         (scan)
  );

  pac_judge u_judge (
    .scan      (scan),
    .is_public (judge_public),
    .kind      (judge_kind)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && held_end) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && held_end) begin
      out_public <= judge_public;
      out_kind   <= judge_kind;
    end
  end

  assign verdict.valid        = out_valid;
  assign verdict.is_public    = out_public;
  assign verdict.address_kind = out_kind;

  a_end_gives_verdict: assert property (@(posedge clk) disable iff (rst)
    advance && held_end |=> out_valid)
    else $error("string end did not load a verdict");

  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    advance && held_end |=> u_scan.state.char_count == 3'd0)
    else $error("scan state not cleared after verdict");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !verdict.ready |-> !(advance && held_end))
    else $error("pending verdict overwritten");

  a_empty_private: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_EMPTY |-> !out_public)
    else $error("empty string judged public");

endmodule
